FILE: hw/rtl/chfa_pkg.sv
package chfa_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 6;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 15;
  localparam int GUARD_BITS = 8;
  localparam int ANG_FRAC   = 20;
  localparam int TABLE_LEN  = 24;
  localparam int HALF_TURN  = 180;
  localparam int FULL_TURN  = 360;

  localparam int NUM_CELLS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STEP_W    = $clog2(TABLE_LEN);

  localparam int XY_W  = IN_W + 1 + GUARD_BITS + 2;
  localparam int ANG_W = 31;

  localparam longint HALF_ANG = longint'(HALF_TURN) << ANG_FRAC;
  localparam longint FULL_ANG = longint'(FULL_TURN) << ANG_FRAC;
  localparam longint RND_ANG  = longint'(1) << (ANG_FRAC - 1 - FRAC_BITS);
  localparam int     OUT_SH   = ANG_FRAC - FRAC_BITS;
  localparam longint FULL_Q   = longint'(FULL_TURN) << FRAC_BITS;
  localparam bit     FULL_Q_FITS = FULL_Q <= (longint'(1) << OUT_W);

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
  } stage_t;

  // Arctangent of 2^-i in degrees times 2^20, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      5'd0:    r = ANG_W'(47185920);
      5'd1:    r = ANG_W'(27855475);
      5'd2:    r = ANG_W'(14718068);
      5'd3:    r = ANG_W'(7471121);
      5'd4:    r = ANG_W'(3750058);
      5'd5:    r = ANG_W'(1876857);
      5'd6:    r = ANG_W'(938658);
      5'd7:    r = ANG_W'(469357);
      5'd8:    r = ANG_W'(234682);
      5'd9:    r = ANG_W'(117342);
      5'd10:   r = ANG_W'(58671);
      5'd11:   r = ANG_W'(29335);
      5'd12:   r = ANG_W'(14668);
      5'd13:   r = ANG_W'(7334);
      5'd14:   r = ANG_W'(3667);
      5'd15:   r = ANG_W'(1833);
      5'd16:   r = ANG_W'(917);
      5'd17:   r = ANG_W'(458);
      5'd18:   r = ANG_W'(229);
      5'd19:   r = ANG_W'(115);
      5'd20:   r = ANG_W'(57);
      5'd21:   r = ANG_W'(29);
      5'd22:   r = ANG_W'(14);
      5'd23:   r = ANG_W'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/chfa_cell.sv
module chfa_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [chfa_pkg::STEP_W-1:0]         step_i,
  input  logic                                valid_i,
  input  chfa_pkg::stage_t                    stage_i,
  output logic                                valid_o,
  output chfa_pkg::stage_t                    stage_o
);

  logic             valid_q;
  chfa_pkg::stage_t stage_q;
  chfa_pkg::stage_t stage_d;
  logic signed [chfa_pkg::XY_W-1:0]  xs;
  logic signed [chfa_pkg::XY_W-1:0]  ys;
  logic signed [chfa_pkg::ANG_W-1:0] da;

  always_comb begin
    xs = stage_i.x >>> step_i;
    ys = stage_i.y >>> step_i;
    da = chfa_pkg::atan_deg(step_i);
    if (!stage_i.y[chfa_pkg::XY_W-1]) begin
      stage_d.x   = stage_i.x + ys;
      stage_d.y   = stage_i.y - xs;
      stage_d.ang = stage_i.ang + da;
    end else begin
      stage_d.x   = stage_i.x - ys;
      stage_d.y   = stage_i.y + xs;
      stage_d.ang = stage_i.ang - da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

FILE: hw/rtl/chfa_wrap.sv
module chfa_wrap (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  chfa_pkg::stage_t                 stage_i,
  output logic                             valid_o,
  output logic [chfa_pkg::OUT_W-1:0]       heading_o
);

  localparam logic signed [chfa_pkg::ANG_W-1:0] Full = chfa_pkg::ANG_W'(chfa_pkg::FULL_ANG);
  localparam logic signed [chfa_pkg::ANG_W-1:0] Rnd  = chfa_pkg::ANG_W'(chfa_pkg::RND_ANG);
  localparam logic signed [chfa_pkg::ANG_W-1:0] FullQ = chfa_pkg::ANG_W'(chfa_pkg::FULL_Q);

  logic                              valid_q;
  logic [chfa_pkg::OUT_W-1:0]        heading_q;
  logic [chfa_pkg::OUT_W-1:0]        heading_d;
  logic signed [chfa_pkg::ANG_W-1:0] ang_w;
  logic signed [chfa_pkg::ANG_W-1:0] ang_r;
  logic signed [chfa_pkg::ANG_W-1:0] h;

  always_comb begin
    ang_w = stage_i.ang;
    if (ang_w < 0) begin
      ang_w = ang_w + Full;
    end
    if (ang_w >= Full) begin
      ang_w = ang_w - Full;
    end
    ang_r = ang_w + Rnd;
    h     = ang_r >>> chfa_pkg::OUT_SH;
    if (h >= FullQ) begin
      h = '0;
    end
    heading_d = h[chfa_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      heading_q <= heading_d;
    end
  end

  assign valid_o   = valid_q;
  assign heading_o = heading_q;

endmodule

FILE: hw/rtl/compass_heading_from_axes.sv
// Compass heading from two magnetometer axes.
// The input channel carries one beat per sample: signed X and Y readings on
// x_axis_i and y_axis_i, qualified by valid_i and held off by stall_o. The
// output channel carries one beat per sample: the heading in degrees times 64
// on heading_q6_o, from 0 up to just below 360 degrees, qualified by valid_o
// and held off by stall_i.
// A beat is taken every cycle while stall_o is low, so the throughput is one
// sample per cycle. Each accepted beat passes through one register for the
// quadrant pre-rotation, one cell per CORDIC iteration (16 cells), one
// register for the wrap and rounding, and the output register.
// While the receiver stalls, the output register holds its beat and one more
// beat drops into a skid register; stall_o is that skid register's flag, so
// the whole chain freezes as soon as that register fills and nothing is lost.
// Reset is asynchronous and active low. It clears every valid flag, so the
// chain comes up empty, and the block takes a beat in the first cycle after.
module compass_heading_from_axes (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic signed [chfa_pkg::IN_W-1:0]  x_axis_i,
  input  logic signed [chfa_pkg::IN_W-1:0]  y_axis_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic [chfa_pkg::OUT_W-1:0]        heading_q6_o
);

  localparam int N = chfa_pkg::NUM_CELLS;

  logic                             en;
  logic                             in_valid_q;
  chfa_pkg::stage_t                 st0_q;
  chfa_pkg::stage_t                 st0_d;
  logic signed [chfa_pkg::XY_W-1:0] x_ext;
  logic signed [chfa_pkg::XY_W-1:0] y_ext;
  logic                             neg;

  logic             cell_valid [N+1];
  chfa_pkg::stage_t cell_stage [N+1];

  logic                       wrap_valid;
  logic [chfa_pkg::OUT_W-1:0] wrap_heading;

  logic                       out_valid_q;
  logic [chfa_pkg::OUT_W-1:0] out_q;
  logic                       skid_valid_q;
  logic [chfa_pkg::OUT_W-1:0] skid_q;

  assign en      = !skid_valid_q;
  assign stall_o = skid_valid_q;

  always_comb begin
    x_ext = chfa_pkg::XY_W'(x_axis_i);
    y_ext = chfa_pkg::XY_W'(y_axis_i);
    if (x_axis_i == '0) begin
      x_ext = chfa_pkg::XY_W'(1);
    end
    neg = x_ext[chfa_pkg::XY_W-1];
    if (neg) begin
      x_ext = -x_ext;
      y_ext = -y_ext;
    end
    st0_d.x   = x_ext <<< chfa_pkg::GUARD_BITS;
    st0_d.y   = y_ext <<< chfa_pkg::GUARD_BITS;
    st0_d.ang = neg ? chfa_pkg::ANG_W'(chfa_pkg::HALF_ANG) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st0_q <= st0_d;
    end
  end

  assign cell_valid[0] = in_valid_q;
  assign cell_stage[0] = st0_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    chfa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (chfa_pkg::STEP_W'(k)),
      .valid_i (cell_valid[k]),
      .stage_i (cell_stage[k]),
      .valid_o (cell_valid[k+1]),
      .stage_o (cell_stage[k+1])
    );
  end

  chfa_wrap u_wrap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (cell_valid[N]),
    .stage_i   (cell_stage[N]),
    .valid_o   (wrap_valid),
    .heading_o (wrap_heading)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!skid_valid_q) begin
      if (wrap_valid) begin
        if (!out_valid_q || !stall_i) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end else if (!stall_i) begin
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      if (wrap_valid) begin
        if (!out_valid_q || !stall_i) begin
          out_q <= wrap_heading;
        end else begin
          skid_q <= wrap_heading;
        end
      end
    end else if (!stall_i) begin
      out_q <= skid_q;
    end
  end

  assign valid_o      = out_valid_q;
  assign heading_q6_o = out_q;

`ifndef SYNTH
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid register holds a beat while the output register is empty.");

  a_stalled_beat_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stall_i && wrap_valid && !skid_valid_q) |=> skid_valid_q)
    else $error("A beat arriving at a stalled output did not enter the skid register.");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !stall_i) |=> (!skid_valid_q && out_valid_q))
    else $error("Skid register did not drain into the output register.");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!chfa_pkg::FULL_Q_FITS ||
                     (chfa_pkg::ANG_W'(out_q) < chfa_pkg::ANG_W'(chfa_pkg::FULL_Q))))
    else $error("Heading is outside one full turn.");
`endif

endmodule

FILE: tb/sv/compass_heading_from_axes_tb.sv
`timescale 1ns / 1ps

module compass_heading_from_axes_tb;

  localparam int RANDOM_SAMPLES = 1100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic signed [chfa_pkg::IN_W-1:0] x;
    logic signed [chfa_pkg::IN_W-1:0] y;
  } sample_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             valid_i      = 1'b0;
  logic                             stall_o;
  logic signed [chfa_pkg::IN_W-1:0] x_axis_i     = '0;
  logic signed [chfa_pkg::IN_W-1:0] y_axis_i     = '0;
  logic                             valid_o;
  logic                             stall_i      = 1'b0;
  logic [chfa_pkg::OUT_W-1:0]       heading_q6_o;

  sample_t                    sample_q[$];
  logic [chfa_pkg::OUT_W-1:0] heading_exp_q[$];
  sample_t                    next_beat;
  logic [chfa_pkg::OUT_W-1:0] want_heading;
  int                         burst_left   = 0;
  int                         gap_left     = 0;
  int                         err_count    = 0;
  int                         idle_cycles  = 0;
  stall_mode_e                stall_mode   = STALL_NONE;
  int                         mode_left    = 0;
  int unsigned                stall_phase  = 0;

  longint atan_q20 [chfa_pkg::TABLE_LEN] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658, 469357, 234682, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7
  };

  compass_heading_from_axes dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .x_axis_i     (x_axis_i),
    .y_axis_i     (y_axis_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .heading_q6_o (heading_q6_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [chfa_pkg::OUT_W-1:0] heading_of(
      logic signed [chfa_pkg::IN_W-1:0] xa,
      logic signed [chfa_pkg::IN_W-1:0] ya);
    longint x, y, xs, ys, ang, full, h;
    x    = xa;
    y    = ya;
    ang  = 0;
    full = longint'(chfa_pkg::FULL_TURN) << chfa_pkg::ANG_FRAC;
    if (x == 0) x = 1;
    if (x < 0) begin
      x   = -x;
      y   = -y;
      ang = longint'(chfa_pkg::HALF_TURN) << chfa_pkg::ANG_FRAC;
    end
    x = x <<< chfa_pkg::GUARD_BITS;
    y = y <<< chfa_pkg::GUARD_BITS;
    for (int i = 0; i < chfa_pkg::CORDIC_STEPS && i < chfa_pkg::TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        ang = ang + atan_q20[i];
      end else begin
        x   = x - ys;
        y   = y + xs;
        ang = ang - atan_q20[i];
      end
    end
    if (ang < 0) ang = ang + full;
    if (ang >= full) ang = ang - full;
    h = (ang + (longint'(1) << (chfa_pkg::ANG_FRAC - 1 - chfa_pkg::FRAC_BITS)))
        >>> (chfa_pkg::ANG_FRAC - chfa_pkg::FRAC_BITS);
    if (h >= (longint'(chfa_pkg::FULL_TURN) << chfa_pkg::FRAC_BITS)) h = 0;
    return h[chfa_pkg::OUT_W-1:0];
  endfunction

  task automatic push_sample(input logic signed [chfa_pkg::IN_W-1:0] x,
                             input logic signed [chfa_pkg::IN_W-1:0] y);
    sample_t s;
    s.x = x;
    s.y = y;
    sample_q.push_back(s);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else begin
      if (valid_i && !stall_o) begin
        heading_exp_q.push_back(heading_of(x_axis_i, y_axis_i));
      end
      if (!valid_i || !stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          valid_i  <= 1'b0;
        end else if (sample_q.size() != 0) begin
          next_beat = sample_q.pop_front();
          valid_i  <= 1'b1;
          x_axis_i <= next_beat.x;
          y_axis_i <= next_beat.y;
          if (burst_left <= 1) begin
            burst_left <= int'($urandom_range(1, 48));
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      mode_left  <= int'($urandom_range(20, 200));
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     stall_i <= 1'b0;
      STALL_RANDOM:   stall_i <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: stall_i <= ((stall_phase % 5) < 2);
      default:        stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (heading_exp_q.size() == 0) begin
        $error("heading_q6: beat with nothing expected, actual %0d", heading_q6_o);
        err_count++;
      end else begin
        want_heading = heading_exp_q.pop_front();
        if (heading_q6_o !== want_heading) begin
          $error("heading_q6: expected %0d, actual %0d", want_heading, heading_q6_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned                      kind;
    logic signed [chfa_pkg::IN_W-1:0] rx, ry;

    push_sample(16'sd0, 16'sd0);
    push_sample(16'sd0, 16'sd1);
    push_sample(16'sd0, -16'sd1);
    push_sample(16'sd0, 16'sh7FFF);
    push_sample(16'sd0, 16'sh8000);
    push_sample(16'sh7FFF, 16'sd0);
    push_sample(16'sh8000, 16'sd0);
    push_sample(16'sh8000, 16'sh8000);
    push_sample(16'sh7FFF, 16'sh7FFF);
    push_sample(16'sh8000, 16'sh7FFF);
    push_sample(16'sh7FFF, 16'sh8000);
    push_sample(16'sd1, 16'sd0);
    push_sample(-16'sd1, 16'sd0);
    push_sample(16'sd1, 16'sd1);
    push_sample(-16'sd1, -16'sd1);
    push_sample(16'sd1, -16'sd1);
    push_sample(-16'sd1, 16'sd1);
    push_sample(16'sd1000, -16'sd1);
    push_sample(16'sh7FFF, -16'sd1);
    push_sample(-16'sd1, 16'sh8000);
    push_sample(16'sh5555, 16'shAAAA);
    push_sample(16'shAAAA, 16'sh5555);

    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      kind = $urandom_range(0, 9);
      rx   = chfa_pkg::IN_W'($urandom);
      ry   = chfa_pkg::IN_W'($urandom);
      if (kind < 2) begin
        rx = chfa_pkg::IN_W'($urandom_range(0, 16));
        rx = rx - 16'sd8;
        ry = chfa_pkg::IN_W'($urandom_range(0, 16));
        ry = ry - 16'sd8;
      end else if (kind < 4) begin
        rx = chfa_pkg::IN_W'($urandom_range(0, 6));
        rx = rx - 16'sd3;
      end else if (kind < 5) begin
        ry = chfa_pkg::IN_W'($urandom_range(0, 6));
        ry = ry - 16'sd3;
      end
      push_sample(rx, ry);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sample_q.size() != 0 || valid_i || heading_exp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
